FILE: rtl/lrp_pkg.sv
// shared types, register codes and the sigmoid lookup table for logistic regression predict
package lrp_pkg;

  localparam int FEATURES        = 4;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int IDX_W           = $clog2(SIGMOID_ENTRIES);
  localparam int PROD_W          = 32;
  localparam int Z_W             = PROD_W + $clog2(FEATURES + 1);
  localparam int FIU_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int U_W             = 20;
  localparam int SCALED_W        = U_W + IDX_W + 1;

  typedef logic signed [15:0]       q88_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic [15:0]              prob_t;
  typedef logic [IDX_W-1:0]         sig_idx_t;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS            = 3'd0,
    REG_WEIGHT_ZERO     = 3'd1,
    REG_WEIGHT_ONE      = 3'd2,
    REG_WEIGHT_TWO      = 3'd3,
    REG_WEIGHT_THREE    = 3'd4,
    REG_FEATURES_IN_USE = 3'd5
  } cfg_reg_t;

  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(FEATURES);

  // clamp limits in Q16.16: sigmoid input range and Q8.8 score range
  localparam z_t ZC_MIN = z_t'(-524288);
  localparam z_t ZC_MAX = z_t'(524287);
  localparam z_t SC_MIN = z_t'(-8388608);
  localparam z_t SC_MAX = z_t'(8388607);

  localparam logic [63:0] QONE = 64'h1000_0000_0000_0000;

  typedef logic [SIGMOID_ENTRIES-1:0][15:0] sig_table_t;

  // floor(n / d) by shift and subtract, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor((a*b) / 2^60)
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // r / SIGMOID_ENTRIES in Q60
  function automatic logic [63:0] ratio_q60(input logic [63:0] r);
    logic [127:0] t;
    t = {64'd0, r} << 60;
    t = t >> IDX_W;
    return t[63:0];
  endfunction

  // exp(-f) in Q60 by taylor series, 0 <= f <= 1
  function automatic logic [63:0] exp_neg_q60(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = QONE;
    term = QONE;
    for (int n = 1; n < 64; n++) begin
      // once a term reaches zero every later term stays zero
      if (term != 64'd0) begin
        term = udiv64(mul_q60(term, f), 64'(n));
      end
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // entry i holds round(65535 * sigmoid(lower edge of interval i))
  function automatic sig_table_t build_sig_table();
    sig_table_t   tbl;
    logic [63:0]  einv;
    longint       p;
    logic [63:0]  a;
    logic [63:0]  k;
    logic [63:0]  r;
    logic [63:0]  e;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  v;
    einv = exp_neg_q60(QONE);
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      p = longint'(i) * 16 - 8 * longint'(SIGMOID_ENTRIES);
      a = (p < 0) ? 64'(-p) : 64'(p);
      k = a >> IDX_W;
      r = a & 64'(SIGMOID_ENTRIES - 1);
      e = exp_neg_q60(ratio_q60(r));
      for (int j = 0; j <= 8; j++) begin
        if (64'(j) < k) begin
          e = mul_q60(e, einv);
        end
      end
      num = (p >= 0) ? QONE : e;
      den = QONE + e;
      num = num >> 14;
      den = den >> 14;
      v   = udiv64(num * 64'd131070 + den, den << 1);
      tbl[i] = (v > 64'd65535) ? 16'hffff : v[15:0];
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

FILE: rtl/logistic_regression_predict.sv
// top level of the logistic regression predictor: config registers, lanes, merge and output
//
// usage
// - a request carries one row of four signed Q8.8 features on in_feature_*;
//   it is taken at a rising edge with start high and busy low
// - busy stays low: a new request may be given every cycle, so the block
//   sustains one row per clock cycle
// - the result is registered in stages: one for the four multiply lanes,
//   one for the merge adder that adds the bias, and one for the sigmoid
//   table and saturation; out_valid is registered with the last of them
// - each result (out_probability, out_class_bit, out_score) is shown for
//   exactly one cycle with out_valid; the receiver cannot stall, so no
//   result is held back and requests never wait on the output side
// - configuration: cfg_we writes cfg_wdata to the register at cfg_index
//   (bias, four weights, features_in_use); unknown indexes are ignored;
//   write only while no request is in flight
// - features at or beyond features_in_use enter as zero
// - synchronous reset (rst_n low) clears the pipeline valid bits, sets the
//   bias and weights to zero and features_in_use to four
module logistic_regression_predict (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  lrp_pkg::q88_t                      in_feature_zero,
  input  lrp_pkg::q88_t                      in_feature_one,
  input  lrp_pkg::q88_t                      in_feature_two,
  input  lrp_pkg::q88_t                      in_feature_three,
  output logic                               out_valid,
  output lrp_pkg::prob_t                     out_probability,
  output logic                               out_class_bit,
  output lrp_pkg::q88_t                      out_score,
  input  logic                               cfg_we,
  input  logic [lrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lrp_pkg::*;

  // configuration registers
  q88_t             bias_r;
  q88_t             weight_r [FEATURES];
  logic [FIU_W-1:0] fiu_r;

  // request feature row as an array for the lanes
  q88_t  feature [FEATURES];
  logic  lane_en [FEATURES];
  prod_t prod    [FEATURES];

  logic s1_valid_r;
  logic s2_valid;
  z_t   z;

  // a request is taken on every start, since busy never rises
  assign busy = 1'b0;

  assign feature[0] = in_feature_zero;
  assign feature[1] = in_feature_one;
  assign feature[2] = in_feature_two;
  assign feature[3] = in_feature_three;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      for (int i = 0; i < FEATURES; i++) begin
        weight_r[i] <= '0;
      end
      fiu_r <= FIU_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_BIAS) begin
        bias_r <= cfg_wdata;
      end
      for (int i = 0; i < FEATURES; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_WEIGHT_ZERO + i)) begin
          weight_r[i] <= cfg_wdata;
        end
      end
      if (cfg_index == REG_FEATURES_IN_USE) begin
        fiu_r <= cfg_wdata[FIU_W-1:0];
      end
    end
  end

  // stage 1 valid follows accepted requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
    end
  end

  // multiply lanes; a count above the lane count enables every lane
  for (genvar g = 0; g < FEATURES; g++) begin : g_lane
    assign lane_en[g] = (FIU_W'(g) < fiu_r);

    lrp_lane u_lane (
      .clk     (clk),
      .lane_en (lane_en[g]),
      .feature (feature[g]),
      .weight  (weight_r[g]),
      .prod    (prod[g])
    );
  end

  lrp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s1_valid_r),
    .bias      (bias_r),
    .prod      (prod),
    .valid_out (s2_valid),
    .z         (z)
  );

  lrp_sigmoid u_sigmoid (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_in    (s2_valid),
    .z           (z),
    .valid_out   (out_valid),
    .probability (out_probability),
    .class_bit   (out_class_bit),
    .score       (out_score)
  );

endmodule

FILE: rtl/lrp_lane.sv
// one multiply lane: registered weight times feature, zero when the feature is not in use
module lrp_lane (
  input  logic          clk,
  input  logic          lane_en,
  input  lrp_pkg::q88_t feature,
  input  lrp_pkg::q88_t weight,
  output lrp_pkg::prod_t prod
);
  import lrp_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;

  always_comb begin
    prod_nxt = lane_en ? prod_t'(feature) * prod_t'(weight) : '0;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

FILE: rtl/lrp_merge.sv
// merge stage: bias plus the lane products gives the Q16.16 score
module lrp_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  input  lrp_pkg::q88_t  bias,
  input  lrp_pkg::prod_t prod [lrp_pkg::FEATURES],
  output logic           valid_out,
  output lrp_pkg::z_t    z
);
  import lrp_pkg::*;

  logic valid_r;
  z_t   z_r;
  z_t   z_nxt;

  always_comb begin
    z_nxt = z_t'(bias) <<< 8;
    for (int i = 0; i < FEATURES; i++) begin
      z_nxt = z_nxt + z_t'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    z_r <= z_nxt;
  end

  assign valid_out = valid_r;
  assign z         = z_r;

endmodule

FILE: rtl/lrp_sigmoid.sv
// output stage: sigmoid lookup, class decision and saturated Q8.8 score
module lrp_sigmoid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  input  lrp_pkg::z_t   z,
  output logic          valid_out,
  output lrp_pkg::prob_t probability,
  output logic          class_bit,
  output lrp_pkg::q88_t score
);
  import lrp_pkg::*;

  z_t                  zc;
  logic [U_W-1:0]      u;
  logic [SCALED_W-1:0] scaled;
  sig_idx_t            idx;

  logic  valid_r;
  prob_t prob_r;
  prob_t prob_nxt;
  logic  class_r;
  logic  class_nxt;
  q88_t  score_r;
  q88_t  score_nxt;

  always_comb begin
    if (z < ZC_MIN) begin
      zc = ZC_MIN;
    end else if (z > ZC_MAX) begin
      zc = ZC_MAX;
    end else begin
      zc = z;
    end
    // offset by +8.0 so the clamped score is unsigned
    u      = {~zc[U_W-1], zc[U_W-2:0]};
    scaled = SCALED_W'(u) * SCALED_W'(SIGMOID_ENTRIES);
    idx    = scaled[U_W +: IDX_W];

    prob_nxt  = SIG_TABLE[idx];
    class_nxt = ~z[Z_W-1];

    if (z < SC_MIN) begin
      score_nxt = q88_t'(-32768);
    end else if (z > SC_MAX) begin
      score_nxt = q88_t'(32767);
    end else begin
      score_nxt = z[23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    prob_r  <= prob_nxt;
    class_r <= class_nxt;
    score_r <= score_nxt;
  end

  assign valid_out   = valid_r;
  assign probability = prob_r;
  assign class_bit   = class_r;
  assign score       = score_r;

endmodule
